/* hdl/runs_declustering_core_macros.svh */
// Assertion macros shared by the runs declustering RTL.
`ifndef RUNS_DECLUSTERING_CORE_MACROS_SVH
`define RUNS_DECLUSTERING_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("runs declustering check failed");

// Next-cycle implication, checked outside reset.
`define RDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("runs declustering check failed");

`endif

/* hdl/rdc_pkg.sv */
// Shared types and constants of the runs declustering core.
`default_nettype none

package rdc_pkg;

   localparam int LOOKAHEAD_MAX_DEFAULT        = 31;
   localparam int CLUSTER_NUMBER_WIDTH_DEFAULT = 23;

   localparam int RUN_LENGTH_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = RUN_LENGTH_WIDTH;

   localparam logic [RUN_LENGTH_WIDTH-1:0] RUN_LENGTH_RESET     = 5'd3;
   localparam logic [RUN_LENGTH_WIDTH-1:0] LOW_RUN_LENGTH_RESET = 5'd3;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RUN_LENGTH     = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_RUN_LENGTH = 4'd1;

   typedef enum logic [0:0] {
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Commands from the cluster logic to the lookahead queue
   typedef struct packed {
      logic push;
      logic shift;
      logic clear;
      logic above_high;
      logic above_low;
   } queue_ctrl_type;

   // Queue status seen by the cluster logic
   typedef struct packed {
      logic head_high;
      logic high_none;
      logic low_none;
      logic last_slot;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* hdl/rdc_queue.sv */
// Lookahead queue of indicator bits with sliding window counts.
`default_nettype none

module rdc_queue #(
   parameter int LOOKAHEAD_MAX = rdc_pkg::LOOKAHEAD_MAX_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire rdc_pkg::queue_ctrl_type              ctrl,
   input  wire logic [rdc_pkg::RUN_LENGTH_WIDTH-1:0] run_length,
   input  wire logic [rdc_pkg::RUN_LENGTH_WIDTH-1:0] low_run_length,
   output rdc_pkg::queue_status_type                 status
);
   import rdc_pkg::*;

   localparam int DEPTH = LOOKAHEAD_MAX + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(LOOKAHEAD_MAX + 1);

   logic [DEPTH-1:0] high_ff, high_in, high_w;
   logic [DEPTH-1:0] low_ff, low_in, low_w;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    high_cnt_ff, high_cnt_in;
   logic [CW-1:0]    low_cnt_ff, low_cnt_in;
   logic [IW-1:0]    high_len, low_len;
   logic             add_high, add_low;

   // Clip window lengths to the lookahead depth
   always_comb begin
      high_len = (32'(run_length) > 32'(LOOKAHEAD_MAX)) ? IW'(LOOKAHEAD_MAX)
                                                         : IW'(run_length);
      low_len  = (32'(low_run_length) > 32'(LOOKAHEAD_MAX)) ? IW'(LOOKAHEAD_MAX)
                                                             : IW'(low_run_length);
   end

   // Write the new position at the fill point, then slide the windows
   always_comb begin
      high_w = high_ff;
      low_w  = low_ff;
      if (ctrl.push) begin
         high_w[fill_ff[IW-1:0]] = ctrl.above_high;
         low_w[fill_ff[IW-1:0]]  = ctrl.above_low;
      end
      add_high = ctrl.push && (fill_ff < FW'(high_len)) && ctrl.above_high;
      add_low  = ctrl.push && (fill_ff < FW'(low_len)) && ctrl.above_low;

      high_cnt_in = high_cnt_ff + CW'(add_high)
                    + CW'(ctrl.shift & high_w[high_len]) - CW'(ctrl.shift & high_w[0]);
      low_cnt_in  = low_cnt_ff + CW'(add_low)
                    + CW'(ctrl.shift & low_w[low_len]) - CW'(ctrl.shift & low_w[0]);

      high_in = ctrl.shift ? (high_w >> 1) : high_w;
      low_in  = ctrl.shift ? (low_w >> 1) : low_w;

      fill_in = fill_ff;
      if (ctrl.push && !ctrl.shift) begin
         fill_in = fill_ff + FW'(1);
      end else if (ctrl.shift && !ctrl.push) begin
         fill_in = fill_ff - FW'(1);
      end

      // Drop the whole series
      if (ctrl.clear) begin
         high_in     = '0;
         low_in      = '0;
         fill_in     = '0;
         high_cnt_in = '0;
         low_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff     <= '0;
         low_ff      <= '0;
         fill_ff     <= '0;
         high_cnt_ff <= '0;
         low_cnt_ff  <= '0;
      end else begin
         high_ff     <= high_in;
         low_ff      <= low_in;
         fill_ff     <= fill_in;
         high_cnt_ff <= high_cnt_in;
         low_cnt_ff  <= low_cnt_in;
      end
   end

   // Report the head position and window results
   always_comb begin
      status.head_high = high_ff[0];
      status.high_none = (high_cnt_ff == '0);
      status.low_none  = (low_cnt_ff == '0);
      status.last_slot = (fill_ff == FW'(DEPTH - 1));
      status.empty     = (fill_ff == '0);
   end

endmodule

`default_nettype wire

/* hdl/runs_declustering_core.sv */
// Runs declustering core: a position is decided by the request LOOKAHEAD_MAX later and held;
// it is loaded into the output register by the request LOOKAHEAD_MAX+1 later (or by the flush).
// Throughput: one request per cycle while the output register is free; a series end request
// is followed by a flush that decides each queued position and then finishes, one result
// per step except the first when the series never filled the queue, while no request is taken.
// Reset (synchronous, active high) empties the queue and cluster state; lengths go to 3.
`default_nettype none

module runs_declustering_core #(
   parameter int LOOKAHEAD_MAX        = rdc_pkg::LOOKAHEAD_MAX_DEFAULT,
   parameter int CLUSTER_NUMBER_WIDTH = rdc_pkg::CLUSTER_NUMBER_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_above_high,
   input  wire logic                                req_above_low,
   input  wire logic                                req_series_end,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [CLUSTER_NUMBER_WIDTH-1:0]          rsp_cluster_number,
   output logic                                     rsp_cluster_start,
   output logic                                     rsp_cluster_end,
   output logic                                     rsp_final_result,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rdc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import rdc_pkg::*;

`include "runs_declustering_core_macros.svh"

   logic [RUN_LENGTH_WIDTH-1:0]     run_length_ff, low_run_length_ff;
   state_type                       state_ff, state_in;
   logic                            in_cluster_ff, in_cluster_in;
   logic [CLUSTER_NUMBER_WIDTH-1:0] counter_ff, counter_in;
   logic [CLUSTER_NUMBER_WIDTH-1:0] pend_number_ff;
   logic                            pend_start_ff, pend_valid_ff;
   logic                            rsp_valid_ff;
   logic [CLUSTER_NUMBER_WIDTH-1:0] rsp_number_ff;
   logic                            rsp_start_ff, rsp_end_ff, rsp_final_ff;

   queue_ctrl_type                  qctrl;
   queue_status_type                qstat;
   logic                            out_free, req_fire, decide, finish, emit;
   logic [CLUSTER_NUMBER_WIDTH-1:0] number;
   logic                            start, close_prev, emit_end;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff     <= RUN_LENGTH_RESET;
         low_run_length_ff <= LOW_RUN_LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RUN_LENGTH:     run_length_ff     <= csr_data;
            CSR_LOW_RUN_LENGTH: low_run_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Lookahead queue
   rdc_queue #(
      .LOOKAHEAD_MAX(LOOKAHEAD_MAX)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (qctrl),
      .run_length    (run_length_ff),
      .low_run_length(low_run_length_ff),
      .status        (qstat)
   );

   // Sequence control: take requests, or flush the queue after a series end
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_RUN) && out_free;
      req_fire  = req_valid && req_ready;
      decide    = 1'b0;
      finish    = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            decide = req_fire && !req_series_end && qstat.last_slot;
            if (req_fire && req_series_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            decide = out_free && !qstat.empty;
            finish = out_free && qstat.empty;
            if (finish) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase

      qctrl.push       = req_fire;
      qctrl.shift      = decide;
      qctrl.clear      = finish;
      qctrl.above_high = req_above_high;
      qctrl.above_low  = req_above_low;
   end

   // Decide the cluster membership of the head position
   always_comb begin
      in_cluster_in = in_cluster_ff;
      counter_in    = counter_ff;
      number        = '0;
      start         = 1'b0;
      close_prev    = 1'b0;
      if (qstat.head_high) begin
         if (!in_cluster_ff) begin
            in_cluster_in = 1'b1;
            start         = 1'b1;
            if (counter_ff != '1) begin
               counter_in = counter_ff + CLUSTER_NUMBER_WIDTH'(1);
            end
         end
         number = counter_in;
      end else if (in_cluster_ff) begin
         if (qstat.high_none || qstat.low_none) begin
            in_cluster_in = 1'b0;
            close_prev    = 1'b1;
         end else begin
            number = counter_ff;
         end
      end
      emit     = (decide && pend_valid_ff) || finish;
      emit_end = finish ? in_cluster_ff : close_prev;
   end

   // Cluster state and held result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         in_cluster_ff <= 1'b0;
         counter_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            in_cluster_ff <= 1'b0;
            counter_ff    <= '0;
            pend_valid_ff <= 1'b0;
         end else if (decide) begin
            in_cluster_ff <= in_cluster_in;
            counter_ff    <= counter_in;
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (decide) begin
         pend_number_ff <= number;
         pend_start_ff  <= start;
      end
   end

   // Output register: load on emit, release when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_number_ff <= pend_number_ff;
         rsp_start_ff  <= pend_start_ff;
         rsp_end_ff    <= emit_end;
         rsp_final_ff  <= finish;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cluster_number = rsp_number_ff;
   assign rsp_cluster_start  = rsp_start_ff;
   assign rsp_cluster_end    = rsp_end_ff;
   assign rsp_final_result   = rsp_final_ff;

   // Checks
   `RDC_ASSERT_NOW(a_emit_has_room, emit, out_free)
   `RDC_ASSERT_NOW(a_start_numbered, rsp_valid_ff && rsp_start_ff, rsp_number_ff != '0)
   `RDC_ASSERT_NEXT(a_end_blocks_input, req_fire && req_series_end, !req_ready)
   `RDC_ASSERT_NEXT(a_finish_final, finish, rsp_valid_ff && rsp_final_ff && !pend_valid_ff)

endmodule

`default_nettype wire
